/* hdl/bae_pkg.sv */
`timescale 1ns / 1ps

package bae_pkg;

  // Width of the configured probability and of the serial multiplier operand.
  localparam int ZP_BITS = 16;
  localparam logic [ZP_BITS-1:0] ZP_RESET = 16'h8000;

  // Pending underflow counter and the follow count that reports it.
  localparam int FOLLOW_BITS = 16;
  localparam logic [FOLLOW_BITS-1:0] PENDING_MAX = '1;

  localparam int PRECISION_DEFAULT = 16;

  // Results one input beat may produce; any beyond this are dropped.
  localparam int MAX_RESULTS = 18;
  localparam int RES_CNT_BITS = $clog2(MAX_RESULTS + 1);

  // Request from the sequencer to the output stage.
  typedef struct packed {
    logic                   put;
    logic                   close;
    logic                   code_bit;
    logic [FOLLOW_BITS-1:0] follow;
    logic                   overflow;
  } res_req_t;

endpackage

/* hdl/binary_arithmetic_encoder_core.sv */
`timescale 1ns / 1ps
// Each item is accepted, multiplied bit-serially, applied to the interval in an update step,
// then renormalized step by step; at end of message two termination results follow, and the
// item closes. A result beat moves to the output register when the next beat or the close of
// its item arrives. A new item is accepted only once the previous one has closed.
// Reset (synchronous, active high) restores the full interval, clears the pending count and
// overflow flag, and sets the zero probability to one half.
module binary_arithmetic_encoder_core #(
  parameter int PRECISION_BITS = bae_pkg::PRECISION_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              data_bit,
  input  logic                              end_of_message,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              code_bit,
  output logic [bae_pkg::FOLLOW_BITS-1:0]   follow_count,
  output logic                              pending_overflow,
  output logic                              last_result,
  input  logic                              cfg_we,
  input  logic [bae_pkg::ZP_BITS-1:0]       cfg_wdata
);

  localparam int P = PRECISION_BITS;
  localparam int W = PRECISION_BITS + 1;

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_MUL    = 7'b0000010,
    ST_UPDATE = 7'b0000100,
    ST_RENORM = 7'b0001000,
    ST_TERM1  = 7'b0010000,
    ST_TERM2  = 7'b0100000,
    ST_FLUSH  = 7'b1000000
  } state_t;

  state_t                               state;
  logic [bae_pkg::ZP_BITS-1:0]          zp;
  logic [P-1:0]                         low;
  logic [P-1:0]                         high;
  logic [bae_pkg::FOLLOW_BITS-1:0]      pending;
  logic                                 ovf_seen;
  logic                                 bit_r;
  logic                                 eom_r;
  logic [bae_pkg::RES_CNT_BITS-1:0]     res_cnt;

  logic [W-1:0]      range_w;
  logic [W-1:0]      share_raw;
  logic [W-1:0]      share_nz;
  logic [W-1:0]      share;
  logic [W-1:0]      low_plus;
  logic              mul_start;
  logic              mul_done;
  logic              e1;
  logic              e2;
  logic              e3;
  logic              cap_full;
  logic              term_bit;
  logic              emit_ready;
  logic              step_ok;
  bae_pkg::res_req_t req;

  bae_mul #(
    .W(W)
  ) u_mul (
    .clk    (clk),
    .rst    (rst),
    .start  (mul_start),
    .mcand  (range_w),
    .mplier (zp),
    .done   (mul_done),
    .prod   (share_raw)
  );

  bae_emit u_emit (
    .clk              (clk),
    .rst              (rst),
    .req              (req),
    .ready            (emit_ready),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .code_bit         (code_bit),
    .follow_count     (follow_count),
    .pending_overflow (pending_overflow),
    .last_result      (last_result)
  );

  always_comb begin
    in_stall  = (state != ST_IDLE);
    mul_start = (state == ST_IDLE) && in_valid;
    range_w   = {1'b0, high} - {1'b0, low} + W'(1);

    // Keep both symbols codable: a zero share becomes one, a full share one less.
    share_nz  = (share_raw == '0) ? W'(1) : share_raw;
    share     = (share_nz >= range_w) ? (range_w - W'(1)) : share_nz;
    low_plus  = {1'b0, low} + share;

    e1       = !high[P-1];
    e2       = low[P-1];
    e3       = (low[P-1:P-2] == 2'b01) && (high[P-1:P-2] == 2'b10);
    cap_full = (res_cnt == bae_pkg::RES_CNT_BITS'(bae_pkg::MAX_RESULTS));
    term_bit = (low[P-1:P-2] != 2'b00);

    req          = '0;
    req.overflow = ovf_seen;
    step_ok      = 1'b1;
    unique case (state)
      ST_RENORM: begin
        if (e1 || e2) begin
          req.put      = !cap_full;
          req.code_bit = !e1;
          req.follow   = pending;
          step_ok      = cap_full || emit_ready;
        end
      end
      ST_TERM1: begin
        req.put      = !cap_full;
        req.code_bit = term_bit;
        req.follow   = pending;
        step_ok      = cap_full || emit_ready;
      end
      ST_TERM2: begin
        req.put      = !cap_full;
        req.code_bit = !term_bit;
        step_ok      = cap_full || emit_ready;
      end
      ST_FLUSH: begin
        req.close = 1'b1;
        step_ok   = emit_ready;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      zp       <= bae_pkg::ZP_RESET;
      low      <= '0;
      high     <= '1;
      pending  <= '0;
      ovf_seen <= 1'b0;
      res_cnt  <= '0;
    end else begin
      if (cfg_we) begin
        zp <= cfg_wdata;
      end
      if (req.put && emit_ready) begin
        res_cnt <= res_cnt + bae_pkg::RES_CNT_BITS'(1);
      end
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            bit_r   <= data_bit;
            eom_r   <= end_of_message;
            res_cnt <= '0;
            state   <= ST_MUL;
          end
        end
        ST_MUL: begin
          if (mul_done) begin
            state <= ST_UPDATE;
          end
        end
        ST_UPDATE: begin
          if (bit_r) begin
            low <= low_plus[P-1:0];
          end else begin
            high <= P'(low_plus - W'(1));
          end
          state <= ST_RENORM;
        end
        ST_RENORM: begin
          if (e1 || e2) begin
            if (step_ok) begin
              if (cap_full) begin
                ovf_seen <= 1'b1;
              end
              pending <= '0;
              low     <= {low[P-2:0], 1'b0};
              high    <= {high[P-2:0], 1'b1};
            end
          end else if (e3) begin
            // Middle-half case: drop the quarter offset while doubling.
            if (pending == bae_pkg::PENDING_MAX) begin
              ovf_seen <= 1'b1;
            end else begin
              pending <= pending + bae_pkg::FOLLOW_BITS'(1);
            end
            low  <= {1'b0, low[P-3:0], 1'b0};
            high <= {1'b1, high[P-3:0], 1'b1};
          end else begin
            state <= eom_r ? ST_TERM1 : ST_FLUSH;
          end
        end
        ST_TERM1: begin
          if (step_ok) begin
            if (cap_full) begin
              ovf_seen <= 1'b1;
            end
            state <= ST_TERM2;
          end
        end
        ST_TERM2: begin
          if (step_ok) begin
            low      <= '0;
            high     <= '1;
            pending  <= '0;
            ovf_seen <= 1'b0;
            state    <= ST_FLUSH;
          end
        end
        ST_FLUSH: begin
          if (step_ok) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

/* hdl/bae_mul.sv */
`timescale 1ns / 1ps

// Bit-serial shift-add multiplier. One multiplier bit is consumed per cycle,
// least significant first, and the accumulator shifts right each cycle, so
// after all bits it holds the product shifted down by the multiplier width.
module bae_mul #(
  parameter int W = 17
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [W-1:0]               mcand,
  input  logic [bae_pkg::ZP_BITS-1:0] mplier,
  output logic                       done,
  output logic [W-1:0]               prod
);

  localparam int CNT_W = $clog2(bae_pkg::ZP_BITS);

  logic                        busy;
  logic [CNT_W-1:0]            cnt;
  logic [W-1:0]                mc;
  logic [bae_pkg::ZP_BITS-1:0] mr;
  logic [W:0]                  sum;

  always_comb begin
    sum = {1'b0, prod} + (mr[0] ? {1'b0, mc} : '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + CNT_W'(1);
        if (cnt == CNT_W'(bae_pkg::ZP_BITS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      prod <= '0;
      mc   <= mcand;
      mr   <= mplier;
    end else if (busy) begin
      prod <= sum[W:1];
      mr   <= mr >> 1;
    end
  end

endmodule

/* hdl/bae_emit.sv */
`timescale 1ns / 1ps

// Output stage. Each new result waits in a holding register until the next
// one arrives or the item closes, so the last result of an item is known
// when it moves into the output register.
module bae_emit (
  input  logic              clk,
  input  logic              rst,
  input  bae_pkg::res_req_t req,
  output logic              ready,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              code_bit,
  output logic [bae_pkg::FOLLOW_BITS-1:0] follow_count,
  output logic              pending_overflow,
  output logic              last_result
);

  logic                            held_valid;
  logic                            held_bit;
  logic [bae_pkg::FOLLOW_BITS-1:0] held_follow;
  logic                            held_ovf;
  logic                            can_push;
  logic                            take;

  always_comb begin
    can_push = !out_valid || !out_stall;
    ready    = !held_valid || can_push;
    take     = ready && (req.put || req.close);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (take && held_valid) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (take) begin
        held_valid <= req.put;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && held_valid) begin
      code_bit         <= held_bit;
      follow_count     <= held_follow;
      pending_overflow <= held_ovf;
      last_result      <= req.close;
    end
    if (ready && req.put) begin
      held_bit    <= req.code_bit;
      held_follow <= req.follow;
      held_ovf    <= req.overflow;
    end
  end

endmodule

/* tb/sv/binary_arithmetic_encoder_core_tb.sv */
`timescale 1ns / 1ps

module binary_arithmetic_encoder_core_tb;

  localparam int PREC          = bae_pkg::PRECISION_DEFAULT;
  localparam int SETTLE_CYCLES = 44;
  localparam int IDLE_LIMIT    = 4000;
  localparam int HOLD_OFF      = 400;
  localparam int MAX_REPORTS   = 10;

  localparam logic [PREC-1:0] HALF_PT   = PREC'(1) << (PREC - 1);
  localparam logic [PREC-1:0] QTR_PT    = PREC'(1) << (PREC - 2);
  localparam logic [PREC-1:0] THREE_QTR = HALF_PT + QTR_PT;

  localparam logic [bae_pkg::ZP_BITS-1:0] ZP_MIN      = 16'd1;
  localparam logic [bae_pkg::ZP_BITS-1:0] ZP_MAX      = 16'hFFFF;
  localparam logic [bae_pkg::ZP_BITS-1:0] ZP_HALF     = 16'h8000;
  localparam logic [bae_pkg::ZP_BITS-1:0] PAIR_WIDE   = 16'd32767;
  localparam logic [bae_pkg::ZP_BITS-1:0] PAIR_NARROW = 16'd4;

  typedef struct packed {
    logic                            cbit;
    logic [bae_pkg::FOLLOW_BITS-1:0] follow;
    logic                            ovf;
    logic                            last;
  } code_beat_t;

  logic                            clk;
  logic                            rst;
  logic                            in_valid;
  logic                            in_stall;
  logic                            data_bit;
  logic                            end_of_message;
  logic                            out_valid;
  logic                            out_stall;
  logic                            code_bit;
  logic [bae_pkg::FOLLOW_BITS-1:0] follow_count;
  logic                            pending_overflow;
  logic                            last_result;
  logic                            cfg_we;
  logic [bae_pkg::ZP_BITS-1:0]     cfg_wdata;

  // Encoder state as the testbench predicts it.
  logic [bae_pkg::ZP_BITS-1:0]     zp_model;
  logic [PREC-1:0]                 lo_model;
  logic [PREC-1:0]                 hi_model;
  logic [bae_pkg::FOLLOW_BITS-1:0] pend_model;
  logic                            ovf_model;

  code_beat_t code_beats_due[$];
  code_beat_t item_beats[$];

  int mismatches    = 0;
  int beats_checked = 0;
  int bits_sent     = 0;
  int messages_sent = 0;
  int idle_cycles   = 0;
  int burst_left    = 0;
  int steady_send   = 0;
  int hold_req      = 0;
  int stall_run     = 0;
  int stall_pct     = 0;

  binary_arithmetic_encoder_core #(
    .PRECISION_BITS(PREC)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .data_bit(data_bit),
    .end_of_message(end_of_message),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .code_bit(code_bit),
    .follow_count(follow_count),
    .pending_overflow(pending_overflow),
    .last_result(last_result),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  function automatic void add_beat(input logic b,
                                   input logic [bae_pkg::FOLLOW_BITS-1:0] follow);
    code_beat_t beat;
    if (item_beats.size() >= bae_pkg::MAX_RESULTS) begin
      ovf_model = 1'b1;
    end else begin
      beat.cbit   = b;
      beat.follow = follow;
      beat.ovf    = ovf_model;
      beat.last   = 1'b0;
      item_beats.insert(item_beats.size(), beat);
    end
  endfunction

  task automatic encode_bit(input logic bit_in, input logic eom);
    logic [PREC:0]                  span;
    logic [PREC+bae_pkg::ZP_BITS:0] prod;
    logic [PREC:0]                  share;
    logic                           first;
    logic                           renorm;
    code_beat_t                     beat;
    int                             i;
    item_beats.delete();
    span  = {1'b0, hi_model} - {1'b0, lo_model} + (PREC+1)'(1);
    prod  = (PREC+bae_pkg::ZP_BITS+1)'(span) * (PREC+bae_pkg::ZP_BITS+1)'(zp_model);
    share = prod[bae_pkg::ZP_BITS +: PREC+1];
    // Both symbols must keep a nonempty share of the interval.
    if (share == '0) share = (PREC+1)'(1);
    if (share >= span) share = span - (PREC+1)'(1);
    if (!bit_in) hi_model = PREC'({1'b0, lo_model} + share - (PREC+1)'(1));
    else lo_model = PREC'({1'b0, lo_model} + share);

    renorm = 1'b1;
    while (renorm) begin
      if (hi_model < HALF_PT) begin
        add_beat(1'b0, pend_model);
        pend_model = '0;
      end else if (lo_model >= HALF_PT) begin
        add_beat(1'b1, pend_model);
        pend_model = '0;
        lo_model = lo_model - HALF_PT;
        hi_model = hi_model - HALF_PT;
      end else if (lo_model >= QTR_PT && hi_model < THREE_QTR) begin
        if (pend_model == bae_pkg::PENDING_MAX) ovf_model = 1'b1;
        else pend_model = pend_model + bae_pkg::FOLLOW_BITS'(1);
        lo_model = lo_model - QTR_PT;
        hi_model = hi_model - QTR_PT;
      end else begin
        renorm = 1'b0;
      end
      if (renorm) begin
        lo_model = lo_model << 1;
        hi_model = (hi_model << 1) | PREC'(1);
      end
    end

    if (eom) begin
      first = (lo_model < QTR_PT) ? 1'b0 : 1'b1;
      add_beat(first, pend_model);
      add_beat(~first, '0);
      lo_model   = '0;
      hi_model   = '1;
      pend_model = '0;
      ovf_model  = 1'b0;
    end

    for (i = 0; i < item_beats.size(); i++) begin
      beat = item_beats[i];
      beat.last = (i == item_beats.size() - 1);
      code_beats_due.insert(code_beats_due.size(), beat);
    end
  endtask

  task automatic flag_failure(input string msg);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("%s", msg);
  endtask

  always @(posedge clk) begin
    code_beat_t want;
    if (!rst && out_valid && !out_stall) begin
      beats_checked++;
      if (code_beats_due.size() == 0) begin
        flag_failure($sformatf("Unexpected code beat: bit %0b follow %0d ovf %0b last %0b",
                               code_bit, follow_count, pending_overflow, last_result));
      end else begin
        want = code_beats_due.pop_front();
        if (want.cbit !== code_bit || want.follow !== follow_count ||
            want.ovf !== pending_overflow || want.last !== last_result) begin
          flag_failure($sformatf(
            "Beat %0d mismatch: expected bit %0b follow %0d ovf %0b last %0b, got %0b %0d %0b %0b",
            beats_checked, want.cbit, want.follow, want.ovf, want.last,
            code_bit, follow_count, pending_overflow, last_result));
        end
      end
    end
  end

  // The receiver alternates stretches of differing stall density; a pending hold-off wins.
  always @(negedge clk) begin
    if (hold_req > 0) begin
      out_stall = 1'b1;
      hold_req--;
    end else begin
      if (stall_run == 0) begin
        stall_run = $urandom_range(4, 40);
        case ($urandom_range(0, 3))
          0: stall_pct = 0;
          1: stall_pct = 25;
          2: stall_pct = 50;
          default: stall_pct = 85;
        endcase
      end
      stall_run--;
      out_stall = ($urandom_range(0, 99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Timeout: no beat moved for %0d cycles", IDLE_LIMIT);
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  task automatic send_item(input logic bit_in, input logic eom);
    int gap;
    @(negedge clk);
    if (!steady_send && burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    if (burst_left > 0) burst_left--;
    in_valid       = 1'b1;
    data_bit       = bit_in;
    end_of_message = eom;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    encode_bit(bit_in, eom);
    bits_sent++;
    if (eom) messages_sent++;
  endtask

  // Waits for every predicted beat, then long enough for a beat-free item to finish.
  task automatic settle();
    @(negedge clk);
    in_valid   = 1'b0;
    burst_left = 0;
    while (code_beats_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_zero_prob(input logic [bae_pkg::ZP_BITS-1:0] value);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we   = 1'b0;
    zp_model = value;
  endtask

  // From the full interval, these two bits leave [half-1, half], which then takes
  // PREC-1 middle-half steps to reopen, adding that many pending bits.
  task automatic underflow_pair();
    set_zero_prob(PAIR_WIDE);
    send_item(1'b1, 1'b0);
    settle();
    set_zero_prob(PAIR_NARROW);
    send_item(1'b0, 1'b0);
    settle();
  endtask

  task automatic test_extremes();
    send_item(1'b0, 1'b0);
    send_item(1'b1, 1'b0);
    send_item(1'b0, 1'b1);
    settle();
    // A one at the top probability collapses the interval to a point: 16 beats
    // plus the two that close the message.
    set_zero_prob(ZP_MAX);
    send_item(1'b1, 1'b1);
    send_item(1'b0, 1'b0);
    send_item(1'b0, 1'b0);
    send_item(1'b1, 1'b1);
    settle();
    // Below the full interval, the zero share truncates to nothing and is raised to one.
    set_zero_prob(ZP_MIN);
    send_item(1'b0, 1'b1);
    send_item(1'b1, 1'b0);
    send_item(1'b1, 1'b0);
    send_item(1'b0, 1'b1);
  endtask

  task automatic test_underflow();
    settle();
    repeat (3) underflow_pair();
    send_item(1'b0, 1'b0);
    send_item(1'b1, 1'b1);
    settle();
    // Lower bound ends above one quarter, so termination starts with a one.
    set_zero_prob(PAIR_WIDE);
    send_item(1'b1, 1'b1);
  endtask

  task automatic test_backpressure();
    int i;
    settle();
    set_zero_prob(bae_pkg::ZP_BITS'($urandom_range(20000, 45000)));
    @(posedge clk);
    hold_req    = HOLD_OFF;
    steady_send = 1;
    for (i = 0; i < 40; i++) begin
      send_item(1'($urandom_range(0, 1)), (i == 39) || ($urandom_range(0, 9) == 0));
    end
    steady_send = 0;
    settle();
  endtask

  task automatic test_random_messages();
    int                          phase;
    int                          sent;
    int                          len;
    int                          bias;
    int                          i;
    logic [bae_pkg::ZP_BITS-1:0] zp_pick;
    for (phase = 0; phase < 6; phase++) begin
      case (phase)
        0: zp_pick = ZP_MIN;
        1: zp_pick = ZP_MAX;
        2: zp_pick = bae_pkg::ZP_BITS'($urandom_range(1, 2000));
        3: zp_pick = bae_pkg::ZP_BITS'($urandom_range(63000, 65535));
        default: zp_pick = bae_pkg::ZP_BITS'($urandom_range(1, 65535));
      endcase
      settle();
      set_zero_prob(zp_pick);
      sent = 0;
      while (sent < 10) begin
        len  = ($urandom_range(0, 4) == 0) ? 1 : $urandom_range(2, 24);
        // Half of the messages follow the configured statistics.
        bias = $urandom_range(0, 1) ? int'(zp_pick) : int'(ZP_HALF);
        for (i = 0; i < len; i++) begin
          send_item($urandom_range(0, 65535) >= bias, i == len - 1);
        end
        sent += len;
      end
    end
  endtask

  initial begin
    clk            = 1'b0;
    rst            = 1'b1;
    in_valid       = 1'b0;
    data_bit       = 1'b0;
    end_of_message = 1'b0;
    out_stall      = 1'b0;
    cfg_we         = 1'b0;
    cfg_wdata      = '0;
    zp_model       = bae_pkg::ZP_RESET;
    lo_model       = '0;
    hi_model       = '1;
    pend_model     = '0;
    ovf_model      = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_extremes();
    test_underflow();
    test_backpressure();
    test_random_messages();

    settle();
    $display("Encoded %0d bits in %0d messages and checked %0d code beats.",
             bits_sent, messages_sent, beats_checked);
    $display("Probabilities from 1 to 65535, long output hold-off, chains of middle-half steps.");
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
